// ===== src/arp_res_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP resolver package
// Shared types, codes and the request-frame byte function.
// ----------------------------------------------------------------------------
package arp_res_pkg;

   // input commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_POLL  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX       = 2'd0;
   localparam logic [1:0] KIND_RESOLVED = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT  = 2'd2;

   // register indexes (byte address is 8 * index)
   localparam logic [2:0] REG_OWN_MAC   = 3'd0;
   localparam logic [2:0] REG_OWN_IP    = 3'd1;
   localparam logic [2:0] REG_PEER_IP   = 3'd2;
   localparam logic [2:0] REG_MAX_POLLS = 3'd3;
   localparam logic [2:0] REG_RESEND    = 3'd4;

   localparam int unsigned CSR_AW = 6;

   localparam logic [5:0] FRAME_LEN  = 6'd42;
   localparam logic [5:0] FRAME_LAST = 6'd41;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // ethertype, hardware/protocol type and size, operation request
   localparam logic [7:0] ARP_FIXED [10] = '{
      8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
   };

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic        tx_final;
      logic [47:0] resolved_mac;
   } rsp_word_type;

   // work handed from the front to the back
   typedef struct packed {
      logic        send_req;   // emit the 42-byte request
      logic        send_res;   // then one status word
      logic [1:0]  kind;
      logic [47:0] mac;
   } job_type;

   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         3'd0:    b = mac[47:40];
         3'd1:    b = mac[39:32];
         3'd2:    b = mac[31:24];
         3'd3:    b = mac[23:16];
         3'd4:    b = mac[15:8];
         3'd5:    b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         2'd0:    b = ip[31:24];
         2'd1:    b = ip[23:16];
         2'd2:    b = ip[15:8];
         default: b = ip[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] request_byte(input logic [5:0]  p,
                                               input logic [47:0] own_mac,
                                               input logic [31:0] own_ip,
                                               input logic [31:0] peer_ip);
      logic [5:0] d;
      logic [7:0] b;
      d = 6'd0;
      b = 8'h00;
      if (p < 6'd6) begin
         b = 8'hFF;
      end else if (p < 6'd12) begin
         d = p - 6'd6;
         b = mac_byte(own_mac, d[2:0]);
      end else if (p < 6'd22) begin
         d = p - 6'd12;
         b = ARP_FIXED[d[3:0]];
      end else if (p < 6'd28) begin
         d = p - 6'd22;
         b = mac_byte(own_mac, d[2:0]);
      end else if (p < 6'd32) begin
         d = p - 6'd28;
         b = ip_byte(own_ip, d[1:0]);
      end else if (p < 6'd38) begin
         b = 8'h00;
      end else begin
         d = p - 6'd38;
         b = ip_byte(peer_ip, d[1:0]);
      end
      return b;
   endfunction

endpackage

// ===== src/arp_res_front.sv =====
// ----------------------------------------------------------------------------
// ARP resolver front end
// Takes commands, checks received frames, counts tries and queues work.
// ----------------------------------------------------------------------------
module arp_res_front import arp_res_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_word_type req_word,
   input  logic         queue_full,
   input  logic [31:0]  peer_ip,
   input  logic [9:0]   max_polls,
   input  logic [9:0]   resend_interval,
   output logic         req_stall,
   output logic         job_push,
   output job_type      job
);

   typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DONE} phase_type;

   phase_type   phase_ff, phase_in;
   logic [9:0]  poll_ff, poll_in;
   logic [9:0]  resend_ff, resend_in;
   logic [5:0]  pos_ff, pos_in;
   logic        match_ff, match_in;
   logic [47:0] mac_ff, mac_in;

   logic        accept;
   logic [9:0]  try_poll;
   logic [10:0] resend_sum;
   logic [9:0]  try_resend;
   logic        try_timeout;
   logic [5:0]  b_pos;
   logic        b_match;
   logic [47:0] b_mac;
   logic [5:0]  ip_off;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;

   // one try: advance the counters (resend held at interval 0), check timeout
   always_comb begin
      try_poll   = poll_ff + 10'd1;
      resend_sum = {1'b0, resend_ff} + 11'd1;
      if (resend_interval == 10'd0) begin
         try_resend = resend_ff;
      end else if (resend_sum >= {1'b0, resend_interval}) begin
         try_resend = 10'd0;
      end else begin
         try_resend = resend_sum[9:0];
      end
      try_timeout = (try_poll >= max_polls);
   end

   // per-offset check of a received byte
   always_comb begin
      b_pos   = pos_ff;
      b_match = match_ff;
      b_mac   = mac_ff;
      ip_off  = pos_ff - 6'd28;
      if (pos_ff < FRAME_LEN) begin
         b_pos = pos_ff + 6'd1;
         if (pos_ff == 6'd12) begin
            if (req_word.rx_byte != 8'h08) b_match = 1'b0;
         end else if (pos_ff == 6'd13) begin
            if (req_word.rx_byte != 8'h06) b_match = 1'b0;
         end else if (pos_ff == 6'd20) begin
            if (req_word.rx_byte != 8'h00) b_match = 1'b0;
         end else if (pos_ff == 6'd21) begin
            if (req_word.rx_byte != 8'h02) b_match = 1'b0;
         end else if (pos_ff >= 6'd22 && pos_ff < 6'd28) begin
            b_mac = {mac_ff[39:0], req_word.rx_byte};
         end else if (pos_ff >= 6'd28 && pos_ff < 6'd32) begin
            if (req_word.rx_byte != ip_byte(peer_ip, ip_off[1:0])) b_match = 1'b0;
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      poll_in   = poll_ff;
      resend_in = resend_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      mac_in    = mac_ff;
      job       = '0;
      if (accept) begin
         case (req_word.cmd)
            CMD_START: begin
               poll_in      = 10'd0;
               resend_in    = 10'd0;
               pos_in       = 6'd0;
               match_in     = 1'b1;
               mac_in       = 48'd0;
               phase_in     = PH_WAIT;
               job.send_req = 1'b1;
            end
            CMD_BYTE: begin
               if (phase_ff == PH_WAIT) begin
                  if (!req_word.final_byte) begin
                     pos_in   = b_pos;
                     match_in = b_match;
                     mac_in   = b_mac;
                  end else begin
                     pos_in   = 6'd0;
                     match_in = 1'b1;
                     mac_in   = 48'd0;
                     if (b_pos >= FRAME_LEN && b_match) begin
                        job.send_res = 1'b1;
                        job.kind     = KIND_RESOLVED;
                        job.mac      = b_mac;
                        phase_in     = PH_DONE;
                     end else begin
                        poll_in   = try_poll;
                        resend_in = try_resend;
                        if (try_timeout) begin
                           job.send_res = 1'b1;
                           job.kind     = KIND_TIMEOUT;
                           phase_in     = PH_DONE;
                        end
                     end
                  end
               end
            end
            CMD_POLL: begin
               if (phase_ff == PH_WAIT) begin
                  job.send_req = (resend_interval != 10'd0) && (poll_ff != 10'd0) &&
                                 (resend_ff == 10'd0);
                  poll_in   = try_poll;
                  resend_in = try_resend;
                  if (try_timeout) begin
                     job.send_res = 1'b1;
                     job.kind     = KIND_TIMEOUT;
                     phase_in     = PH_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign job_push = job.send_req | job.send_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         poll_ff   <= 10'd0;
         resend_ff <= 10'd0;
         pos_ff    <= 6'd0;
         match_ff  <= 1'b1;
         mac_ff    <= 48'd0;
      end else begin
         phase_ff  <= phase_in;
         poll_ff   <= poll_in;
         resend_ff <= resend_in;
         pos_ff    <= pos_in;
         match_ff  <= match_in;
         mac_ff    <= mac_in;
      end
   end

endmodule

// ===== src/arp_res_queue.sv =====
// ----------------------------------------------------------------------------
// ARP resolver job queue
// Short first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module arp_res_queue import arp_res_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/arp_res_back.sv =====
// ----------------------------------------------------------------------------
// ARP resolver back end
// Plays out queued jobs as result words through one output register.
// ----------------------------------------------------------------------------
module arp_res_back import arp_res_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  job_type      head_job,
   input  logic [47:0]  own_mac,
   input  logic [31:0]  own_ip,
   input  logic [31:0]  peer_ip,
   input  logic         rsp_stall,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic [5:0]   pos_ff, pos_in;
   logic         req_done_ff, req_done_in;
   logic         out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      pos_in       = pos_ff;
      req_done_in  = req_done_ff;
      pop          = 1'b0;
      if (out_free) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head_job.send_req && !req_done_ff) begin
               rsp_word_in.kind         = KIND_TX;
               rsp_word_in.tx_byte      = request_byte(pos_ff, own_mac, own_ip, peer_ip);
               rsp_word_in.tx_final     = (pos_ff == FRAME_LAST);
               rsp_word_in.resolved_mac = 48'd0;
               if (pos_ff == FRAME_LAST) begin
                  pos_in = 6'd0;
                  // keep the job when a status word follows the request
                  if (head_job.send_res) begin
                     req_done_in = 1'b1;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 6'd1;
               end
            end else begin
               rsp_word_in.kind         = head_job.kind;
               rsp_word_in.tx_byte      = 8'h00;
               rsp_word_in.tx_final     = 1'b0;
               rsp_word_in.resolved_mac = (head_job.kind == KIND_RESOLVED) ?
                                          head_job.mac : 48'd0;
               req_done_in = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 6'd0;
         req_done_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         req_done_ff  <= req_done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== src/arp_resolver_engine.sv =====
// ----------------------------------------------------------------------------
// ARP resolver engine
// Resolves the MAC address of one IPv4 address by ARP request and reply.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle. Received frame bytes, polls and
// commands are checked by the front end, which hands any result-producing
// work to a four-entry job queue; the back end plays each job out one result
// word per cycle unless the result side stalls. A start, or a poll that
// retransmits, yields 42 transmit words (a status word more if it times out),
// and input keeps flowing meanwhile; it stalls only when four jobs wait in the
// queue. Registers sit at byte address 8 * index on a 64-bit port.
module arp_resolver_engine import arp_res_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;
   logic [31:0] peer_ip_ff;
   logic [9:0]  max_polls_ff;
   logic [9:0]  resend_ff;
   logic [2:0]  reg_index;
   logic        csr_write;

   logic        queue_full;
   logic        job_push;
   job_type     job;
   logic        pop;
   logic        head_valid;
   job_type     head_job;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_AW-1:3];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff   <= 48'd0;
         own_ip_ff    <= 32'h0A00_020F;
         peer_ip_ff   <= 32'h0A00_0202;
         max_polls_ff <= 10'd500;
         resend_ff    <= 10'd64;
      end else if (csr_write) begin
         case (reg_index)
            REG_OWN_MAC:   own_mac_ff   <= pwdata[47:0];
            REG_OWN_IP:    own_ip_ff    <= pwdata[31:0];
            REG_PEER_IP:   peer_ip_ff   <= pwdata[31:0];
            REG_MAX_POLLS: max_polls_ff <= pwdata[9:0];
            REG_RESEND:    resend_ff    <= pwdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_OWN_MAC:   prdata = {16'd0, own_mac_ff};
         REG_OWN_IP:    prdata = {32'd0, own_ip_ff};
         REG_PEER_IP:   prdata = {32'd0, peer_ip_ff};
         REG_MAX_POLLS: prdata = {54'd0, max_polls_ff};
         REG_RESEND:    prdata = {54'd0, resend_ff};
         default:       prdata = 64'd0;
      endcase
   end

   arp_res_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_word        (req_word),
      .queue_full      (queue_full),
      .peer_ip         (peer_ip_ff),
      .max_polls       (max_polls_ff),
      .resend_interval (resend_ff),
      .req_stall       (req_stall),
      .job_push        (job_push),
      .job             (job)
   );

   arp_res_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   arp_res_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .own_mac    (own_mac_ff),
      .own_ip     (own_ip_ff),
      .peer_ip    (peer_ip_ff),
      .rsp_stall  (rsp_stall),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== src/arp_res_checker.sv =====
// ----------------------------------------------------------------------------
// ARP resolver checker
// Port-level properties of the result channel and the register port.
// ----------------------------------------------------------------------------
module arp_res_checker import arp_res_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input rsp_word_type rsp_word,
   input logic         pready
);

   // no result word straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.kind == KIND_TX || rsp_word.kind == KIND_RESOLVED ||
                     rsp_word.kind == KIND_TIMEOUT))
      else $error("unused result kind");

   a_final_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.tx_final |-> rsp_word.kind == KIND_TX)
      else $error("frame end marked on a status word");

   a_mac_only_resolved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind != KIND_RESOLVED |-> rsp_word.resolved_mac == 48'd0)
      else $error("address shown on a word that is not a resolution");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind arp_resolver_engine arp_res_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word),
   .pready    (pready)
);
